### src/modified_laplacian_focus_map_macros.svh
// Assertion macros for the focus map checker.
`ifndef MODIFIED_LAPLACIAN_FOCUS_MAP_MACROS_SVH
`define MODIFIED_LAPLACIAN_FOCUS_MAP_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define MLF_ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("focus map: same-cycle check failed");

// Next-cycle implication, disabled while rst is high.
`define MLF_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("focus map: next-cycle check failed");

`endif

### src/mlf_pkg.sv
// Types and constants shared by the focus map modules.
package mlf_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int MIN_SIZE    = 3;
  localparam int CFG_W       = 12;
  localparam int CFG_INDEX_W = 2;
  localparam int COLUMN_W    = 48;
  localparam int PAIR_W      = 16;
  localparam int COLOR_W     = 48;
  localparam int LINE_W      = COLOR_W + 2 * PAIR_W;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] gray_a;
    logic [7:0] gray_b;
    logic [7:0] color_a0;
    logic [7:0] color_a1;
    logic [7:0] color_a2;
    logic [7:0] color_b0;
    logic [7:0] color_b1;
    logic [7:0] color_b2;
  } pixel_t;

  typedef struct packed {
    logic [7:0] focus_a;
    logic [7:0] focus_b;
    logic [7:0] mean0;
    logic [7:0] mean1;
    logic [7:0] mean2;
    logic       last_of_frame;
  } result_t;

endpackage

### src/mlf_line_store.sv
// Line store memory with read-before-write and write forwarding.
module mlf_line_store #(
  parameter int DEPTH = mlf_pkg::MAX_WIDTH,
  parameter int WIDTH = mlf_pkg::LINE_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] fwd_data;
  logic             fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : rd_q;

endmodule

### src/mlf_window_cell.sv
// One window cell: holds a column and hands it on at each shift.
module mlf_window_cell #(
  parameter int WIDTH = mlf_pkg::COLUMN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (shift) begin
      dout <= din;
    end
  end

endmodule

### src/mlf_focus.sv
// Modified Laplacian of both images and channel means at the window centre.
module mlf_focus (
  input  logic [mlf_pkg::COLUMN_W-1:0] col_old,
  input  logic [mlf_pkg::COLUMN_W-1:0] col_mid,
  input  logic [mlf_pkg::COLUMN_W-1:0] col_new,
  input  logic [mlf_pkg::COLOR_W-1:0]  centre_color,
  input  logic                         last,
  output mlf_pkg::result_t             res
);

  function automatic logic [7:0] lap_term(input logic [7:0] c, input logic [7:0] p,
                                          input logic [7:0] q);
    logic [10:0] t;
    logic [10:0] m;
    begin
      t = {2'b00, c, 1'b0} - {3'b000, p} - {3'b000, q};
      m = t[10] ? (~t + 11'd1) : t;
      return m[7:0];
    end
  endfunction

  function automatic logic [7:0] half_sum(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] s;
    begin
      s = {1'b0, x} + {1'b0, y};
      return s[8:1];
    end
  endfunction

  always_comb begin
    res.focus_a = lap_term(col_mid[23:16], col_mid[7:0], col_mid[39:32])
                + lap_term(col_mid[23:16], col_old[23:16], col_new[23:16]);
    res.focus_b = lap_term(col_mid[31:24], col_mid[15:8], col_mid[47:40])
                + lap_term(col_mid[31:24], col_old[31:24], col_new[31:24]);
    res.mean0 = half_sum(centre_color[7:0], centre_color[31:24]);
    res.mean1 = half_sum(centre_color[15:8], centre_color[39:32]);
    res.mean2 = half_sum(centre_color[23:16], centre_color[47:40]);
    res.last_of_frame = last;
  end

endmodule

### src/modified_laplacian_focus_map.sv
// Focus map top level: raster counters, line store, window cell chain, output register.
// The pixel completing a window is captured with its line store read; its result is then
// registered at the output (two pipeline registers: line store read, output).
// Throughput: one pixel per cycle while not stalled, set by the single line store
// read and write per pixel. Reset clears position counters, window cells, held color and
// pipeline valids and loads 640 x 480; line store contents are not cleared.
module modified_laplacian_focus_map #(
  parameter int MAX_WIDTH  = mlf_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = mlf_pkg::MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  mlf_pkg::pixel_t                 pixel,
  output logic                            result_valid,
  input  logic                            result_stall,
  output mlf_pkg::result_t                result,
  input  logic                            cfg_write,
  input  logic [mlf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mlf_pkg::CFG_W-1:0]       cfg_data
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int HCW = $clog2(MAX_HEIGHT + 1);
  localparam int SW  = (WCW > mlf_pkg::CFG_W) ? WCW : mlf_pkg::CFG_W;
  localparam int SH  = (HCW > mlf_pkg::CFG_W) ? HCW : mlf_pkg::CFG_W;

  logic [mlf_pkg::CFG_W-1:0] frame_width;
  logic [mlf_pkg::CFG_W-1:0] frame_height;
  logic [SW-1:0]             w_use;
  logic [SH-1:0]             h_use;
  logic [SW-1:0]             fw_ext;
  logic [SH-1:0]             fh_ext;

  logic [AW-1:0] col_pos;
  logic [RW-1:0] row_pos;
  logic [AW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [SW-1:0] col_ext;
  logic [SH-1:0] row_ext;
  logic          col_wrap;
  logic          row_wrap;
  logic          cur_res;
  logic          cur_last;
  logic          pixel_accept;

  logic            s1_valid;
  logic            s1_res;
  logic            s1_last;
  logic [AW-1:0]   s1_addr;
  mlf_pkg::pixel_t s1_pixel;
  logic            s1_fire;
  logic            out_free;

  logic [mlf_pkg::LINE_W-1:0]   line_rd;
  logic [mlf_pkg::LINE_W-1:0]   line_wr;
  logic [mlf_pkg::PAIR_W-1:0]   s1_pair;
  logic [mlf_pkg::COLOR_W-1:0]  s1_color;
  logic [mlf_pkg::COLUMN_W-1:0] col_new;
  logic [mlf_pkg::COLUMN_W-1:0] col_mid;
  logic [mlf_pkg::COLUMN_W-1:0] col_old;
  logic [mlf_pkg::COLOR_W-1:0]  centre_color;
  mlf_pkg::result_t             result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= mlf_pkg::RESET_WIDTH;
      frame_height <= mlf_pkg::RESET_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        mlf_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        mlf_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = SW'(frame_width);
    fh_ext = SH'(frame_height);
    if (fw_ext < SW'(mlf_pkg::MIN_SIZE)) begin
      w_use = SW'(mlf_pkg::MIN_SIZE);
    end else if (fw_ext > SW'(MAX_WIDTH)) begin
      w_use = SW'(MAX_WIDTH);
    end else begin
      w_use = fw_ext;
    end
    if (fh_ext < SH'(mlf_pkg::MIN_SIZE)) begin
      h_use = SH'(mlf_pkg::MIN_SIZE);
    end else if (fh_ext > SH'(MAX_HEIGHT)) begin
      h_use = SH'(MAX_HEIGHT);
    end else begin
      h_use = fh_ext;
    end
  end

  always_comb begin
    col_cur  = pixel.frame_start ? '0 : col_pos;
    row_cur  = pixel.frame_start ? '0 : row_pos;
    col_ext  = SW'(col_cur);
    row_ext  = SH'(row_cur);
    col_wrap = (col_ext + SW'(1)) >= w_use;
    row_wrap = (row_ext + SH'(1)) >= h_use;
    cur_res  = (col_ext >= SW'(2)) && (row_ext >= SH'(2))
            && (col_ext < w_use) && (row_ext < h_use);
    cur_last = (col_ext == w_use - SW'(1)) && (row_ext == h_use - SH'(1));
  end

  assign out_free     = !result_valid || !result_stall;
  assign s1_fire      = s1_valid && (!s1_res || out_free);
  assign pixel_stall  = s1_valid && !s1_fire;
  assign pixel_accept = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (pixel_accept) begin
      if (col_wrap) begin
        col_pos <= '0;
        row_pos <= row_wrap ? '0 : row_cur + RW'(1);
      end else begin
        col_pos <= col_cur + AW'(1);
        row_pos <= row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      s1_res   <= cur_res;
      s1_last  <= cur_last;
      s1_addr  <= col_cur;
      s1_pixel <= pixel;
    end
  end

  assign s1_pair  = {s1_pixel.gray_b, s1_pixel.gray_a};
  assign s1_color = {s1_pixel.color_b2, s1_pixel.color_b1, s1_pixel.color_b0,
                     s1_pixel.color_a2, s1_pixel.color_a1, s1_pixel.color_a0};
  assign col_new  = {s1_pair, line_rd[2*mlf_pkg::PAIR_W-1:0]};
  assign line_wr  = {s1_color, s1_pair, line_rd[2*mlf_pkg::PAIR_W-1:mlf_pkg::PAIR_W]};

  mlf_line_store #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (mlf_pkg::LINE_W)
  ) u_line (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (pixel_accept),
    .rd_addr (col_cur),
    .wr_en   (s1_fire),
    .wr_addr (s1_addr),
    .wr_data (line_wr),
    .rd_data (line_rd)
  );

  mlf_window_cell #(.WIDTH(mlf_pkg::COLUMN_W)) u_cell_mid (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_fire),
    .din   (col_new),
    .dout  (col_mid)
  );

  mlf_window_cell #(.WIDTH(mlf_pkg::COLUMN_W)) u_cell_old (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_fire),
    .din   (col_mid),
    .dout  (col_old)
  );

  mlf_window_cell #(.WIDTH(mlf_pkg::COLOR_W)) u_cell_color (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_fire),
    .din   (line_rd[mlf_pkg::LINE_W-1:2*mlf_pkg::PAIR_W]),
    .dout  (centre_color)
  );

  mlf_focus u_focus (
    .col_old      (col_old),
    .col_mid      (col_mid),
    .col_new      (col_new),
    .centre_color (centre_color),
    .last         (s1_last),
    .res          (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && s1_res) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_res) begin
      result <= result_next;
    end
  end

endmodule

### src/mlf_checker.sv
// Port-level checker for the focus map, bound to the top level.
`include "modified_laplacian_focus_map_macros.svh"

module mlf_checker (
  input logic             clk,
  input logic             rst,
  input logic             pixel_stall,
  input logic             result_valid,
  input logic             result_stall,
  input mlf_pkg::result_t result
);

  `MLF_ASSERT_IMPLY(a_stall_from_output, clk, rst, pixel_stall, result_valid && result_stall)
  `MLF_ASSERT_IMPLY(a_idle_after_reset, clk, 1'b0, $past(rst), !result_valid)
  `MLF_ASSERT_NEXT(a_valid_held, clk, rst, result_valid && result_stall, result_valid)
  `MLF_ASSERT_NEXT(a_payload_held, clk, rst, result_valid && result_stall, $stable(result))

endmodule

bind modified_laplacian_focus_map mlf_checker u_mlf_checker (.*);
